@@ rtl/ssort_pkg.sv @@
// Shared widths, defaults and result record for the stack sort stream core.
`default_nettype none
package ssort_pkg;

    localparam int unsigned SAMPLE_W            = 32;
    localparam int unsigned STACK_DEPTH_DEFAULT = 32;

    typedef struct packed {
        logic                overflow;
        logic                run_end;
        logic [SAMPLE_W-1:0] sorted_value;
    } result_t;

endpackage
`default_nettype wire

@@ rtl/stack_sort_stream_core.sv @@
// Stack sort stream core: single-stack sort of a stream of signed 32-bit values.
// Each accepted value pops every stored value strictly smaller than it, top first, onto
// the result stream, then is pushed; a value with s_tlast set flushes the whole stack
// afterwards and the last flushed value carries m_tlast. A value arriving at a full stack
// that pops nothing is dropped and one result with m_tuser (overflow) set and zero data is
// given. Steps: a value is accepted in ST_IDLE; each pop or flushed entry is given in ST_CMP or
// ST_FLUSH, and then ST_LOAD_C or ST_LOAD_F loads the next top of stack from the stack RAM,
// whose read data is registered; the final push or drop is done in ST_CMP. A pop, flush
// or overflow result waits while a result is still held in the output register and
// m_tready is low. The input is taken only while no item is in work, but the next item is
// taken while a result still waits in the output register.
`default_nettype none
module stack_sort_stream_core #(
    parameter int unsigned STACK_DEPTH = ssort_pkg::STACK_DEPTH_DEFAULT
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ssort_pkg::SAMPLE_W-1:0] s_tdata,   // [31:0] sample_value
    input  wire logic                           s_tlast,   // is_final
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic      [ssort_pkg::SAMPLE_W-1:0] m_tdata,   // [31:0] sorted_value
    output logic                                m_tlast,   // run_end
    output logic                                m_tuser    // [0] overflow
);
    import ssort_pkg::*;

    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned FW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_CMP    = 3'd1;
    localparam logic [2:0] ST_LOAD_C = 3'd2;
    localparam logic [2:0] ST_FLUSH  = 3'd3;
    localparam logic [2:0] ST_LOAD_F = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [FW-1:0]       fill_reg, fill_next;
    logic [SAMPLE_W-1:0] top_reg, top_next;
    logic [SAMPLE_W-1:0] x_reg, x_next;
    logic                fin_reg, fin_next;
    logic                m_valid_reg;
    result_t             m_data_reg;

    logic                emit;
    result_t             emit_item;
    logic                can_emit;
    logic                pop_now;
    logic                ram_we;
    logic [FW-1:0]       fill_m2;
    logic [SAMPLE_W-1:0] ram_rdata;

    assign can_emit = !m_valid_reg || m_tready;
    assign pop_now  = (fill_reg != '0) && ($signed(top_reg) < $signed(x_reg));
    assign fill_m2  = fill_reg - FW'(2);

    ssort_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (x_reg),
        .raddr (fill_m2[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        fill_next  = fill_reg;
        top_next   = top_reg;
        x_next     = x_reg;
        fin_next   = fin_reg;
        s_tready   = 1'b0;
        ram_we     = 1'b0;
        emit       = 1'b0;
        emit_item  = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    x_next     = s_tdata;
                    fin_next   = s_tlast;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                if (pop_now) begin
                    if (can_emit) begin
                        emit                   = 1'b1;
                        emit_item.sorted_value = top_reg;
                        fill_next              = fill_reg - FW'(1);
                        state_next             = ST_LOAD_C;
                    end
                end else if (fill_reg == FW'(STACK_DEPTH)) begin
                    if (can_emit) begin
                        emit               = 1'b1;
                        emit_item.overflow = 1'b1;
                        state_next         = fin_reg ? ST_FLUSH : ST_IDLE;
                    end
                end else begin
                    ram_we     = 1'b1;
                    top_next   = x_reg;
                    fill_next  = fill_reg + FW'(1);
                    state_next = fin_reg ? ST_FLUSH : ST_IDLE;
                end
            end
            ST_LOAD_C: begin
                top_next   = ram_rdata;
                state_next = ST_CMP;
            end
            ST_FLUSH: begin
                if (fill_reg == '0) begin
                    state_next = ST_IDLE;
                end else if (can_emit) begin
                    emit                   = 1'b1;
                    emit_item.sorted_value = top_reg;
                    emit_item.run_end      = (fill_reg == FW'(1));
                    fill_next              = fill_reg - FW'(1);
                    state_next             = ST_LOAD_F;
                end
            end
            ST_LOAD_F: begin
                top_next   = ram_rdata;
                state_next = ST_FLUSH;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        top_reg <= top_next;
        x_reg   <= x_next;
        fin_reg <= fin_next;
        if (emit) begin
            m_data_reg <= emit_item;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg.sorted_value;
    assign m_tlast  = m_data_reg.run_end;
    assign m_tuser  = m_data_reg.overflow;

    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(STACK_DEPTH))
        else $error("stack fill above depth");

    a_accept_to_cmp: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_CMP))
        else $error("accepted transaction did not start compare");

    a_pop_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && !emit_item.overflow) |=> (fill_reg == $past(fill_reg) - FW'(1)))
        else $error("pop did not decrement fill");

    a_last_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && emit_item.run_end) |=> (fill_reg == '0 && state_reg == ST_LOAD_F))
        else $error("run end with stack not empty");

    a_emit_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !emit)
        else $error("result overwritten while stalled");

endmodule
`default_nettype wire

@@ rtl/ssort_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ssort_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ test/stack_sort_stream_checker.sv @@
// Checker for the stack sort stream core: shadow stack predictor and result comparison.
module stack_sort_stream_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [ssort_pkg::SAMPLE_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [ssort_pkg::SAMPLE_W-1:0] m_tdata,
    input  logic                           m_tlast,
    input  logic                           m_tuser,
    output int unsigned                    error_count,
    output int unsigned                    results_owed
);
    import ssort_pkg::*;

    localparam int unsigned DEPTH = STACK_DEPTH_DEFAULT;

    logic [SAMPLE_W-1:0] shadow_stack [DEPTH];
    int unsigned         shadow_fill;
    result_t             owed_results [$];

    function automatic result_t make_result(logic [SAMPLE_W-1:0] value, logic end_flag,
                                            logic ovf);
        result_t r;
        r.sorted_value = value;
        r.run_end      = end_flag;
        r.overflow     = ovf;
        return r;
    endfunction

    // pop smaller values, push or drop, then flush on the final value
    task automatic sort_step(input logic [SAMPLE_W-1:0] value, input logic final_flag);
        while (shadow_fill > 0 && $signed(shadow_stack[shadow_fill-1]) < $signed(value)) begin
            shadow_fill--;
            owed_results.push_back(make_result(shadow_stack[shadow_fill], 1'b0, 1'b0));
        end
        if (shadow_fill < DEPTH) begin
            shadow_stack[shadow_fill] = value;
            shadow_fill++;
        end else begin
            owed_results.push_back(make_result('0, 1'b0, 1'b1));
        end
        if (final_flag) begin
            while (shadow_fill > 0) begin
                shadow_fill--;
                owed_results.push_back(make_result(shadow_stack[shadow_fill],
                                                   shadow_fill == 0, 1'b0));
            end
        end
    endtask

    always @(posedge aclk) begin
        result_t     want;
        int unsigned errs;
        errs = 0;
        if (!aresetn) begin
            shadow_fill = 0;
            owed_results.delete();
            error_count <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (owed_results.size() == 0) begin
                    $error("unexpected result transaction: sorted_value %0d",
                           $signed(m_tdata));
                    errs++;
                end else begin
                    want = owed_results.pop_front();
                    if (m_tdata !== want.sorted_value) begin
                        $error("sorted_value mismatch: expected %0d, got %0d",
                               $signed(want.sorted_value), $signed(m_tdata));
                        errs++;
                    end
                    if (m_tlast !== want.run_end) begin
                        $error("run_end mismatch: expected %0b, got %0b",
                               want.run_end, m_tlast);
                        errs++;
                    end
                    if (m_tuser !== want.overflow) begin
                        $error("overflow mismatch: expected %0b, got %0b",
                               want.overflow, m_tuser);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                sort_step(s_tdata, s_tlast);
            end
            error_count <= error_count + errs;
        end
        results_owed <= owed_results.size();
    end

endmodule

@@ test/stack_sort_stream_core_tb.sv @@
// Testbench top for the stack sort stream core: clock, reset, stimulus, flow control, verdict.
module stack_sort_stream_core_tb;

    import ssort_pkg::*;

    localparam int unsigned SAMPLES_TARGET = 470;
    localparam int unsigned IDLE_LIMIT     = 3000;
    localparam int unsigned SETTLE_CYCLES  = 100;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [SAMPLE_W-1:0] s_tdata  = '0;
    logic                s_tlast  = 1'b0;
    logic                m_tready = 1'b0;
    logic                s_tready;
    logic                m_tvalid;
    logic [SAMPLE_W-1:0] m_tdata;
    logic                m_tlast;
    logic                m_tuser;

    int unsigned error_count;
    int unsigned results_owed;
    int unsigned samples_sent = 0;
    int unsigned idle_cycles  = 0;
    int unsigned ready_hold   = 0;
    int unsigned tx_burst     = 0;

    always #6 aclk = ~aclk;

    stack_sort_stream_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    stack_sort_stream_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tlast      (s_tlast),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .error_count  (error_count),
        .results_owed (results_owed)
    );

    // receiver stalls: mostly short, a few long, occasional long stall-free stretches
    always @(posedge aclk) begin
        int unsigned pick;
        if (ready_hold == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(50, 200);
            end else if (pick < 60) begin
                m_tready   <= 1'b1;
                ready_hold <= $urandom_range(0, 4);
            end else if (pick < 92) begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end else begin
                m_tready   <= 1'b0;
                ready_hold <= $urandom_range(10, 40);
            end
        end else begin
            ready_hold <= ready_hold - 1;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (tx_burst > 0) begin
            tx_burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            tx_burst = $urandom_range(30, 100);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic final_flag);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= final_flag;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
    endtask

    task automatic random_run(input bit narrow);
        int unsigned         length;
        logic [SAMPLE_W-1:0] v;
        length = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(1, 12);
        for (int unsigned i = 0; i < length; i++) begin
            v = narrow ? $urandom_range(0, 15) - 32'd8 : $urandom;
            send_sample(v, i == length - 1);
        end
    endtask

    // non-increasing run, deep enough to reach and pass a full stack when length exceeds the depth
    task automatic fill_stack(input int unsigned length, input bit drop_final);
        logic [SAMPLE_W-1:0] level;
        logic [SAMPLE_W-1:0] next_level;
        level = $urandom;
        for (int unsigned i = 0; i < length; i++) begin
            send_sample(level, drop_final && i == length - 1);
            next_level = level - $urandom_range(0, 3);
            if ($signed(next_level) <= $signed(level)) level = next_level;
        end
        if (!drop_final) send_sample($urandom, 1'b1);
    endtask

    initial begin
        int unsigned pick;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_sample(32'd5, 1'b1);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1);
        send_sample(32'd7, 1'b0);
        send_sample(32'd7, 1'b0);
        send_sample(32'd7, 1'b1);
        send_sample(32'd3, 1'b0);
        send_sample(32'd1, 1'b0);
        send_sample(32'd2, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'd0, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0);
        send_sample(32'd1, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h8000_0000, 1'b1);
        send_sample(32'd0, 1'b0);
        send_sample(32'hFFFF_FFFE, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b1);
        drain_results();

        // full stack: final value dropped, then overflow followed by a random final value
        fill_stack(33, 1'b1);
        fill_stack(36, 1'b0);

        while (samples_sent < SAMPLES_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                random_run(1'b0);
            end else if (pick < 70) begin
                random_run(1'b1);
            end else if (pick < 82) begin
                fill_stack($urandom_range(30, 38), $urandom_range(0, 1));
            end else begin
                repeat ($urandom_range(1, 4)) send_sample($urandom, $urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 19) == 0) drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0 && results_owed == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

@@ stack_sort_stream_core.f @@
rtl/ssort_pkg.sv
rtl/ssort_ram.sv
rtl/stack_sort_stream_core.sv
test/stack_sort_stream_checker.sv
test/stack_sort_stream_core_tb.sv
